// ----- design/ssgc_pkg.sv -----
package ssgc_pkg;

    // Sizing of the cache and of its stored fields.
    localparam int CAPACITY_DEF = 64;
    localparam int TAG_W        = 21;
    localparam int SCORE_W      = 8;
    localparam int SLOT_W       = 8;
    localparam int FILL_W       = 9;

    localparam logic [SCORE_W-1:0] SCORE_MAX   = 8'd255;
    localparam logic [SCORE_W-1:0] ENTRY_SCORE = 8'd5;
    localparam logic [SCORE_W-1:0] SCORE_LAST  = 8'd1;
    localparam logic [TAG_W-1:0]   SPACE_CODE  = 21'h20;

    // Item modes.
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_AGE    = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_INSERTED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [1:0] {OP_NONE, OP_HIT, OP_INSERT, OP_AGE} ssgc_op_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [TAG_W-1:0] codepoint;
        logic             wide_in;
    } ssgc_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] slot;
        logic       wide_out;
        logic [6:0] evicted;
    } ssgc_result_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [SCORE_W-1:0] score;
        logic               wide;
        logic [SLOT_W-1:0]  slot;
    } ssgc_entry_t;

    // Command broadcast to every cell in the update cycle.
    typedef struct packed {
        ssgc_op_t           op;
        logic [TAG_W-1:0]   code;
        logic [SCORE_W-1:0] hit_score;
        ssgc_entry_t        new_entry;
        logic [FILL_W-1:0]  fill;
    } ssgc_cmd_t;

    // What a cell hands to its right-hand neighbor.
    typedef struct packed {
        ssgc_entry_t entry;
        logic        run;
        logic        tail;
    } ssgc_link_t;

endpackage

// ----- design/score_sorted_glyph_cache.sv -----
// Score-sorted glyph cache built as a row of entry cells.
// Input channel: an item (mode, codepoint, wide_in) is taken at a rising edge
// where start is high and busy is low. Mode 0 looks a codepoint up, mode 1
// inserts it (or counts a hit if present), mode 2 ages every score by one.
// A codepoint of zero is handled as a space.
// Result channel: done is high for exactly one cycle with the result item on
// result; the receiver cannot stall, so it must take it in that cycle.
// Sequence: the accepting edge registers the item and starts the compare cycle,
// which compares the key against every cell and picks the lowest free slot;
// the update cycle then moves entries between neighboring cells, and the result
// and done are registered at its end.
// Overlap: busy is high only during the compare cycle, and a new item may be
// taken while the previous one is updating.
// Reset clears the fill count and marks every bitmap slot free; entry cells
// are not cleared since only filled cells are ever read.
// Slot numbers and the eviction count are cut to their result field widths.
module score_sorted_glyph_cache
    import ssgc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  ssgc_item_t   item,
    output logic         busy,
    output logic         done,
    output ssgc_result_t result
);

    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [1:0] {S_IDLE, S_MATCH, S_UPDATE} state_t;

    state_t             state_reg;
    logic               busy_reg;
    logic               done_reg;
    ssgc_result_t       result_reg;
    logic [1:0]         mode_reg;
    logic [TAG_W-1:0]   code_reg;
    logic               wide_reg;
    logic               hit_reg;
    ssgc_entry_t        hit_entry_reg;
    logic [CAPACITY-1:0] upto_reg;
    logic [SLOT_W-1:0]  free_slot_reg;
    logic [CAPACITY-1:0] free_map_reg;
    logic [FILL_W-1:0]  fill_reg;

    logic               accept;
    ssgc_cmd_t          cell_cmd;
    ssgc_link_t         link      [CAPACITY];
    ssgc_link_t         left_link [CAPACITY];
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] dying;

    logic               hit_any;
    ssgc_entry_t        hit_entry;
    logic [CAPACITY-1:0] upto_next;
    logic [SLOT_W-1:0]  free_slot;
    logic [CAPACITY-1:0] free_map_next;
    logic [FILL_W-1:0]  fill_next;
    logic [FILL_W-1:0]  evict_cnt;
    ssgc_result_t       result_next;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // Row of cells, each fed by its left neighbor.
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            assign left_link[k] = '0;
        end
        else
        begin : g_body
            assign left_link[k] = link[k-1];
        end

        ssgc_cell #(.INDEX(k)) u_cell
        (
            .clk   (clk),
            .cmd   (cell_cmd),
            .upto  (upto_reg[k]),
            .left  (left_link[k]),
            .link  (link[k]),
            .match (match[k]),
            .dying (dying[k])
        );
    end

    // Compare cycle: select the hit entry, mark cells up to it, find a free slot.
    always_comb
    begin
        hit_any   = 1'b0;
        hit_entry = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            upto_next[k] = !hit_any;
            if (match[k])
            begin
                hit_any   = 1'b1;
                hit_entry = hit_entry | link[k].entry;
            end
        end
        free_slot = '0;
        for (int k = CAPACITY - 1; k >= 0; k--)
        begin
            if (free_map_reg[k])
                free_slot = SLOT_W'(k);
        end
    end

    // Update cycle: choose the cell command, bookkeeping and the result item.
    always_comb
    begin
        cell_cmd.op        = OP_NONE;
        cell_cmd.code      = code_reg;
        cell_cmd.hit_score = hit_entry_reg.score;
        cell_cmd.new_entry = hit_entry_reg;
        cell_cmd.new_entry.score = hit_entry_reg.score + SCORE_LAST;
        cell_cmd.fill      = fill_reg;
        free_map_next      = free_map_reg;
        fill_next          = fill_reg;
        evict_cnt          = FILL_W'($countones(dying));
        result_next        = '0;
        result_next.status = ST_MISS;
        if (state_reg == S_UPDATE)
        begin
            case (mode_reg)
                MODE_LOOKUP, MODE_INSERT:
                begin
                    if (hit_reg)
                    begin
                        result_next.status   = ST_HIT;
                        result_next.slot     = hit_entry_reg.slot[5:0];
                        result_next.wide_out = hit_entry_reg.wide;
                        if (hit_entry_reg.score < SCORE_MAX)
                            cell_cmd.op = OP_HIT;
                    end
                    else if (mode_reg == MODE_INSERT)
                    begin
                        if (fill_reg < FILL_W'(CAPACITY))
                        begin
                            cell_cmd.op              = OP_INSERT;
                            cell_cmd.new_entry.tag   = code_reg;
                            cell_cmd.new_entry.score = ENTRY_SCORE;
                            cell_cmd.new_entry.wide  = wide_reg;
                            cell_cmd.new_entry.slot  = free_slot_reg;
                            free_map_next[free_slot_reg[IDX_W-1:0]] = 1'b0;
                            fill_next            = fill_reg + FILL_W'(1);
                            result_next.status   = ST_INSERTED;
                            result_next.slot     = free_slot_reg[5:0];
                            result_next.wide_out = wide_reg;
                        end
                        else
                        begin
                            result_next.status = ST_FULL;
                        end
                    end
                end
                MODE_AGE:
                begin
                    cell_cmd.op         = OP_AGE;
                    result_next.status  = ST_HIT;
                    result_next.evicted = evict_cnt[6:0];
                    fill_next           = fill_reg - evict_cnt;
                    for (int k = 0; k < CAPACITY; k++)
                    begin
                        if (dying[k])
                            free_map_next[link[k].entry.slot[IDX_W-1:0]] = 1'b1;
                    end
                end
                default:
                begin
                    result_next.status = ST_MISS;
                end
            endcase
        end
    end

    // Sequencer, bookkeeping state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
            mode_reg      <= MODE_LOOKUP;
            code_reg      <= '0;
            wide_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            hit_entry_reg <= '0;
            upto_reg      <= '0;
            free_slot_reg <= '0;
            free_map_reg  <= '1;
            fill_reg      <= '0;
        end
        else
        begin
            done_reg     <= (state_reg == S_UPDATE);
            result_reg   <= result_next;
            free_map_reg <= free_map_next;
            fill_reg     <= fill_next;
            if (state_reg == S_MATCH)
            begin
                hit_reg       <= hit_any;
                hit_entry_reg <= hit_entry;
                upto_reg      <= upto_next;
                free_slot_reg <= free_slot;
            end
            if (accept)
            begin
                mode_reg  <= item.mode;
                code_reg  <= (item.codepoint == '0) ? SPACE_CODE : item.codepoint;
                wide_reg  <= item.wide_in;
                state_reg <= S_MATCH;
                busy_reg  <= 1'b1;
            end
            else
            begin
                case (state_reg)
                    S_MATCH:
                    begin
                        state_reg <= S_UPDATE;
                        busy_reg  <= 1'b0;
                    end
                    S_UPDATE:
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                    end
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    // A result only follows an update cycle.
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_UPDATE))
        else $error("result without update cycle");

    // The fill count never exceeds the capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CAPACITY))
        else $error("fill count above capacity");

    // The number of free slots plus the fill count always equals the capacity.
    a_slot_books: assert property (@(posedge clk) disable iff (!rst_n)
        FILL_W'($countones(free_map_reg)) + fill_reg == FILL_W'(CAPACITY))
        else $error("free map and fill count disagree");

    // An accepted item always goes into the compare cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && state_reg == S_MATCH))
        else $error("accepted item not in compare cycle");
`endif

endmodule

// ----- design/ssgc_cell.sv -----
module ssgc_cell
    import ssgc_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic       clk,
    input  ssgc_cmd_t  cmd,
    input  logic       upto,
    input  ssgc_link_t left,
    output ssgc_link_t link,
    output logic       match,
    output logic       dying
);

    ssgc_entry_t entry_reg;
    ssgc_entry_t entry_next;
    logic        valid;

    // Local status of the entry held here.
    assign valid = FILL_W'(INDEX) < cmd.fill;
    assign match = valid && (entry_reg.tag == cmd.code);
    assign dying = valid && (entry_reg.score == SCORE_LAST);

    assign link.entry = entry_reg;
    assign link.run   = valid && (entry_reg.score == cmd.hit_score);
    assign link.tail  = !valid || (entry_reg.score < ENTRY_SCORE);

    // A raised entry jumps to the head of its score run; the run behind it moves
    // one place right. An insert opens a gap in front of the low-score tail.
    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            OP_HIT:
            begin
                if (upto && left.run)
                    entry_next = left.entry;
                else if (upto && link.run)
                    entry_next = cmd.new_entry;
            end
            OP_INSERT:
            begin
                if (left.tail)
                    entry_next = left.entry;
                else if (link.tail)
                    entry_next = cmd.new_entry;
            end
            OP_AGE:
            begin
                if (valid)
                    entry_next.score = entry_reg.score - SCORE_LAST;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
